/* hw/rtl/pwd_pkg.sv */
// Shared types and constants for the progress watchdog with pause sources.
package pwd_pkg;

    // Width of the restart factor register.
    localparam int FACTOR_BITS = 4;

    // Reset values of the configuration registers.
    localparam int TIMEOUT_RESET = 60000;
    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 4'd2;

    // Register indexes on the configuration port.
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_FACTOR  = 1'b1;

    // Action codes of an input word.
    localparam logic [2:0] ACT_TASK_BEGIN = 3'd0;
    localparam logic [2:0] ACT_TASK_END   = 3'd1;
    localparam logic [2:0] ACT_PROGRESS   = 3'd2;
    localparam logic [2:0] ACT_TEARDOWN   = 3'd3;
    localparam logic [2:0] ACT_INIT_DONE  = 3'd4;
    localparam logic [2:0] ACT_PAUSE      = 3'd5;
    localparam logic [2:0] ACT_RESUME     = 3'd6;
    localparam logic [2:0] ACT_TICK       = 3'd7;

    // Pause and resume sources.
    localparam logic [1:0] SRC_GENERAL    = 2'd0;
    localparam logic [1:0] SRC_BACKGROUND = 2'd1;
    localparam logic [1:0] SRC_POWER      = 2'd2;
    localparam logic [1:0] SRC_INVALID    = 2'd3;

    // Input word: one event or one tick.
    typedef struct packed {
        logic [2:0] action;
        logic [1:0] source;
    } item_t;

    // Result word: status after one input word.
    typedef struct packed {
        logic armed;
        logic paused;
        logic hang_now;
        logic hung;
    } result_t;

endpackage

/* hw/rtl/pwd_cfg.sv */
// Configuration registers of the progress watchdog on an APB-style port.
module pwd_cfg #(
    parameter int TIMEOUT_BITS = 24,
    parameter int DATA_W       = 32,
    parameter int ADDR_W       = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_W-1:0]            paddr,
    input  logic [DATA_W-1:0]            pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready,
    output logic [TIMEOUT_BITS-1:0]      timeout,
    output logic [pwd_pkg::FACTOR_BITS-1:0] factor
);

    logic [TIMEOUT_BITS-1:0]         timeout_reg;
    logic [pwd_pkg::FACTOR_BITS-1:0] factor_reg;
    logic                            reg_index;
    logic                            wr_en;

    // The register index sits just above the byte offset within one register.
    assign reg_index = paddr[ADDR_W-1];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Register writes during the access cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_BITS'(pwd_pkg::TIMEOUT_RESET);
            factor_reg  <= pwd_pkg::FACTOR_RESET;
        end
        else if (wr_en)
        begin
            if (reg_index == pwd_pkg::REG_TIMEOUT)
            begin
                timeout_reg <= pwdata[TIMEOUT_BITS-1:0];
            end
            else
            begin
                factor_reg <= pwdata[pwd_pkg::FACTOR_BITS-1:0];
            end
        end
    end

    // Read back of the addressed register.
    always_comb
    begin
        case (reg_index)
            pwd_pkg::REG_TIMEOUT: prdata = DATA_W'(timeout_reg);
            pwd_pkg::REG_FACTOR:  prdata = DATA_W'(factor_reg);
            default:              prdata = '0;
        endcase
    end

    assign timeout = timeout_reg;
    assign factor  = factor_reg;

endmodule

/* hw/rtl/pwd_core.sv */
// Watchdog state and the single-pass update for one input word.
module pwd_core #(
    parameter int TIMEOUT_BITS = 24,
    parameter int COUNTER_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  pwd_pkg::item_t                  item,
    input  logic [TIMEOUT_BITS-1:0]         timeout,
    input  logic [pwd_pkg::FACTOR_BITS-1:0] factor,
    output pwd_pkg::result_t                result
);

    localparam int TL_W = TIMEOUT_BITS + pwd_pkg::FACTOR_BITS;

    logic [COUNTER_BITS-1:0] arm_reg, arm_next;
    logic [COUNTER_BITS-1:0] snap_reg, snap_next;
    logic [TL_W-1:0]         ticks_reg, ticks_next;
    logic [2:0]              pause_reg, pause_next;
    logic                    teardown_reg, teardown_next;
    logic                    hung_reg, hung_next;

    logic [1:0]                      bump;
    logic [2:0]                      src_mask;
    logic [2:0]                      pause_cleared;
    logic [pwd_pkg::FACTOR_BITS-1:0] reload_factor;
    logic [TL_W-1:0]                 product;
    logic [TL_W-1:0]                 reload_value;
    logic                            hang_now;

    // Source one-hot mask; the invalid source selects nothing.
    assign src_mask = (item.source == pwd_pkg::SRC_INVALID) ? 3'b000 : (3'b001 << item.source);
    assign pause_cleared = pause_reg & ~src_mask;

    // Reload value: timeout scaled after a background or power resume, never zero.
    assign reload_factor = (item.action == pwd_pkg::ACT_RESUME
                            && item.source != pwd_pkg::SRC_GENERAL)
                           ? factor : pwd_pkg::FACTOR_BITS'(1);
    assign product       = TL_W'(timeout) * TL_W'(reload_factor);
    assign reload_value  = (product == '0) ? TL_W'(1) : product;

    // Next state for one word.
    always_comb
    begin
        bump          = 2'd0;
        snap_next     = snap_reg;
        ticks_next    = ticks_reg;
        pause_next    = pause_reg;
        teardown_next = teardown_reg;
        hung_next     = hung_reg;
        hang_now      = 1'b0;
        case (item.action)
            pwd_pkg::ACT_TASK_BEGIN: bump = teardown_reg ? 2'd0 : 2'd1;
            pwd_pkg::ACT_TASK_END:   bump = teardown_reg ? 2'd2 : 2'd1;
            pwd_pkg::ACT_PROGRESS:   bump = 2'd2;
            pwd_pkg::ACT_TEARDOWN:
            begin
                teardown_next = 1'b1;
                bump          = arm_reg[0] ? 2'd0 : 2'd1;
            end
            pwd_pkg::ACT_INIT_DONE:  bump = 2'd1;
            pwd_pkg::ACT_PAUSE:
            begin
                if (src_mask != 3'b000)
                begin
                    bump       = 2'd2;
                    pause_next = pause_reg | src_mask;
                end
            end
            pwd_pkg::ACT_RESUME:
            begin
                if ((pause_reg & src_mask) != 3'b000)
                begin
                    pause_next = pause_cleared;
                    if (pause_cleared == 3'b000)
                    begin
                        ticks_next = reload_value;
                        snap_next  = arm_reg;
                    end
                end
            end
            default:
            begin
                // Tick: count down while running, check progress on expiry.
                if (pause_reg == 3'b000 && ticks_reg != '0)
                begin
                    if (ticks_reg > TL_W'(1))
                    begin
                        ticks_next = ticks_reg - TL_W'(1);
                    end
                    else if (arm_reg[0] && arm_reg == snap_reg)
                    begin
                        hang_now   = 1'b1;
                        hung_next  = 1'b1;
                        ticks_next = '0;
                    end
                    else
                    begin
                        ticks_next = reload_value;
                        snap_next  = arm_reg;
                    end
                end
            end
        endcase
        arm_next = arm_reg + COUNTER_BITS'(bump);
    end

    // State registers advance once per processed word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_reg      <= COUNTER_BITS'(1);
            snap_reg     <= COUNTER_BITS'(1);
            ticks_reg    <= TL_W'(TIMEOUT_BITS'(pwd_pkg::TIMEOUT_RESET));
            pause_reg    <= 3'b000;
            teardown_reg <= 1'b0;
            hung_reg     <= 1'b0;
        end
        else if (fire)
        begin
            arm_reg      <= arm_next;
            snap_reg     <= snap_next;
            ticks_reg    <= ticks_next;
            pause_reg    <= pause_next;
            teardown_reg <= teardown_next;
            hung_reg     <= hung_next;
        end
    end

    assign result.armed    = arm_next[0];
    assign result.paused   = (pause_next != 3'b000);
    assign result.hang_now = hang_now;
    assign result.hung     = hung_next;

`ifndef ASSERT_OFF
    // A declared hang halts the countdown.
    a_hang_halts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && hang_now |=> ticks_reg == '0 && hung_reg)
        else $error("hang did not halt the countdown");

    // The hang flag never clears outside reset.
    a_hung_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        hung_reg |=> hung_reg)
        else $error("hang flag cleared");

    // A tick while paused leaves the countdown untouched.
    a_pause_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.action == pwd_pkg::ACT_TICK && pause_reg != 3'b000
        |=> $stable(ticks_reg) && $stable(arm_reg))
        else $error("countdown moved while paused");

    // Teardown mode is never left.
    a_teardown_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        teardown_reg |=> teardown_reg)
        else $error("teardown mode cleared");
`endif

endmodule

/* hw/rtl/progress_watchdog_with_pause_sources.sv */
// Top level of the progress watchdog with pause sources.
//
// Usage: each word on the item channel is one event (task begin, task end,
// progress, teardown start, init done, pause, resume) or one tick of the
// watchdog time base. For every accepted word exactly one result word
// leaves on the result channel, in order, carrying the armed and paused
// status, a one-word hang pulse and the sticky hang flag.
// The word is taken into the input register, the state update and result
// are computed from it in one pass and loaded into the output register.
// Throughput is one word per cycle while the receiver does not stall;
// the only feedback path is the state update of the core, one register deep.
// When the receiver stalls, the output register holds its word and the
// input register takes one more word before item_ready falls.
// Reset clears both pipeline valid flags, arms the counter, loads the
// countdown with the reset timeout and clears all pause, teardown and hang
// state. The timeout and restart factor registers are written through the
// APB-style port and take effect on the next reload of the countdown.
module progress_watchdog_with_pause_sources #(
    parameter int  TIMEOUT_BITS = 24,
    parameter int  COUNTER_BITS = 32,
    localparam int DATA_W       = (TIMEOUT_BITS > 32) ? 64 : 32,
    localparam int ADDR_W       = (TIMEOUT_BITS > 32) ? 4 : 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  pwd_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output pwd_pkg::result_t  result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic                            in_vld_reg, in_vld_next;
    pwd_pkg::item_t                  in_word_reg;
    logic                            out_vld_reg, out_vld_next;
    pwd_pkg::result_t                out_word_reg;
    pwd_pkg::result_t                core_result;
    logic                            exec;
    logic                            take;
    logic [TIMEOUT_BITS-1:0]         timeout;
    logic [pwd_pkg::FACTOR_BITS-1:0] factor;

    // Configuration registers.
    pwd_cfg #(
        .TIMEOUT_BITS (TIMEOUT_BITS),
        .DATA_W       (DATA_W),
        .ADDR_W       (ADDR_W)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .timeout (timeout),
        .factor  (factor)
    );

    // Watchdog state and single-pass update.
    pwd_core #(
        .TIMEOUT_BITS (TIMEOUT_BITS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (exec),
        .item    (in_word_reg),
        .timeout (timeout),
        .factor  (factor),
        .result  (core_result)
    );

    // A word is processed when there is room in the output register.
    assign exec       = in_vld_reg && (!out_vld_reg || result_ready);
    assign item_ready = !in_vld_reg || exec;
    assign take       = item_valid && item_ready;

    // Valid flags of the two pipeline registers.
    always_comb
    begin
        in_vld_next  = take ? 1'b1 : (exec ? 1'b0 : in_vld_reg);
        out_vld_next = exec ? 1'b1 : (result_ready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg <= item;
        end
        if (exec)
        begin
            out_word_reg <= core_result;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_word_reg;

endmodule
